>>> design/mseu_pkg.sv
// Package for the execute unit: shared widths, opcodes, request structs and a helper function.
`timescale 1ns / 1ps

package mseu_pkg;

    localparam int WORD_W             = 32;
    localparam int REG_IDX_W          = 5;
    localparam int NUM_REGS           = 32;
    localparam int OP_W               = 4;
    localparam int TARGET_W           = 10;
    localparam int PC_OUT_W           = 10;
    localparam int MIDX_W             = 10;
    localparam int MEM_WORDS_DEFAULT  = 1024;
    localparam int PROG_DEPTH_DEFAULT = 1024;
    localparam logic [WORD_W-1:0] DATA_BASE_RESET = 32'h1001_0000;

    // smallest supported program depth is 2**MIN_DEPTH_LOG2
    localparam int MIN_DEPTH_LOG2 = 4;
    localparam int MOD_STEPS      = TARGET_W - MIN_DEPTH_LOG2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_SUBI = 4'd3,
        OP_BEQ  = 4'd4,
        OP_BNE  = 4'd5,
        OP_BLE  = 4'd6,
        OP_J    = 4'd7,
        OP_LI   = 4'd8,
        OP_LW   = 4'd9,
        OP_SW   = 4'd10,
        OP_NOP  = 4'd11
    } op_t;

    // register file write request
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
    } rf_wr_t;

    // data memory access strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } dmem_ctl_t;

    // target modulo depth by restoring subtraction of shifted depths
    function automatic logic [TARGET_W-1:0] target_mod(
        input logic [TARGET_W-1:0] tgt,
        input logic [31:0]         depth
    );
        logic [31:0] rem;
        logic [31:0] step;
        rem = 32'(tgt);
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            step = depth << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[TARGET_W-1:0];
    endfunction

endpackage

>>> design/mips_subset_execute_unit_top.sv
// Top level of the integer subset execute unit: pipeline control, ALU and program counter.
`timescale 1ns / 1ps
//
// Usage
//   Input channel s_*: one decoded instruction word per handshake (s_valid/s_ready).
//   Result channel m_*: one result word per instruction, in order (m_valid/m_ready).
//   cfg_wr_en/cfg_wr_data write the data base address; write only while idle.
// Timing
//   Three-stage pipeline: register file read, execute with data memory access,
//   write-back into the output register. Throughput is one word per cycle while
//   nothing stalls the pipeline, dependent words included: the register file read
//   ports are bypassed from the write-back stage and from the last write, load
//   data is bypassed straight from the memory port.
// Reset
//   Program counter, register file valid bits and data base are reset at once.
//   The data memory is then zeroed one word a cycle, with s_ready low;
//   configuration writes are taken during that time.
// Stall
//   With m_ready low the result is held; up to two more words are taken into the
//   pipeline, after which s_ready drops until the output is taken.
//

module mips_subset_execute_unit_top
    import mseu_pkg::*;
#(
    parameter int MEM_WORDS  = MEM_WORDS_DEFAULT,
    parameter int PROG_DEPTH = PROG_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [WORD_W-1:0]           cfg_wr_data,
    // instruction channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [OP_W-1:0]             s_op,
    input  logic [REG_IDX_W-1:0]        s_dest_reg,
    input  logic [REG_IDX_W-1:0]        s_src_a,
    input  logic [REG_IDX_W-1:0]        s_src_b,
    input  logic signed [WORD_W-1:0]    s_immediate,
    input  logic [TARGET_W-1:0]         s_target,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [PC_OUT_W-1:0]         m_next_pc,
    output logic                        m_branch_taken,
    output logic                        m_reg_write,
    output logic [REG_IDX_W-1:0]        m_write_reg_index,
    output logic signed [WORD_W-1:0]    m_write_value,
    output logic                        m_mem_write,
    output logic [MIDX_W-1:0]           m_mem_index,
    output logic                        m_addr_error
);

    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int PC_W   = $clog2(PROG_DEPTH);

    // configuration and architectural PC
    logic [WORD_W-1:0]    data_base_reg;
    logic [PC_W-1:0]      pc_reg;
    logic [PC_W-1:0]      pc_next;

    // stage 1: operands from the register file
    logic                 s1_valid_reg;
    logic [OP_W-1:0]      s1_op_reg;
    logic [REG_IDX_W-1:0] s1_rd_reg;
    logic [REG_IDX_W-1:0] s1_ra_reg;
    logic [REG_IDX_W-1:0] s1_rb_reg;
    logic [WORD_W-1:0]    s1_imm_reg;
    logic [TARGET_W-1:0]  s1_tgt_reg;

    // stage 2: memory data returns
    logic                 s2_valid_reg;
    logic [PC_OUT_W-1:0]  s2_npc_reg;
    logic                 s2_taken_reg;
    logic                 s2_wr_reg;
    logic [REG_IDX_W-1:0] s2_rd_reg;
    logic [WORD_W-1:0]    s2_val_reg;
    logic                 s2_use_mem_reg;
    logic                 s2_mw_reg;
    logic [MIDX_W-1:0]    s2_midx_reg;
    logic                 s2_err_reg;

    // output register
    logic                 m_valid_reg;
    logic [PC_OUT_W-1:0]  m_next_pc_reg;
    logic                 m_branch_taken_reg;
    logic                 m_reg_write_reg;
    logic [REG_IDX_W-1:0] m_write_reg_index_reg;
    logic [WORD_W-1:0]    m_write_value_reg;
    logic                 m_mem_write_reg;
    logic [MIDX_W-1:0]    m_mem_index_reg;
    logic                 m_addr_error_reg;

    // handshake and flow
    logic                 accept;
    logic                 out_load;
    logic                 s2_adv;
    logic                 s1_adv;
    logic                 s1_go;
    logic                 dmem_busy;

    // datapath
    logic [WORD_W-1:0]    rf_a;
    logic [WORD_W-1:0]    rf_b;
    logic [WORD_W-1:0]    s2_fwd_val;
    logic [WORD_W-1:0]    va;
    logic [WORD_W-1:0]    vb;
    logic [WORD_W-1:0]    diff;
    logic                 pos_ok;
    logic                 neg_ok;
    logic                 addr_ok;
    logic [MEM_AW-1:0]    mem_idx;
    logic [31:0]          mem_idx_wide;
    logic                 alu_wr;
    logic [WORD_W-1:0]    alu_val;
    logic                 taken;
    logic                 is_lw;
    logic                 is_sw;
    logic                 rd_nonzero;
    logic                 ex_wr;
    logic                 ex_use_mem;
    logic [WORD_W-1:0]    ex_val;
    logic                 ex_mw;
    logic                 ex_err;
    logic [MIDX_W-1:0]    ex_midx;
    logic [PC_W-1:0]      pc_inc;
    logic [TARGET_W-1:0]  tgt_mod;
    logic [31:0]          tgt_wide;
    logic [31:0]          npc_wide;
    logic [WORD_W-1:0]    dmem_rd_data;
    rf_wr_t               rf_wr;
    dmem_ctl_t            dm_ctl;

    // pipeline flow: each stage moves when the one ahead has room
    assign out_load = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s2_adv   = !s2_valid_reg || out_load;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign s1_go    = s1_valid_reg && s2_adv;
    assign s_ready  = s1_adv && !dmem_busy;
    assign accept   = s_valid && s_ready;

    // register file, read at acceptance, written from stage 2
    mseu_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (s_src_a),
        .rd_addr_b (s_src_b),
        .wr        (rf_wr),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    // data memory, accessed from stage 1
    mseu_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dm_ctl),
        .addr    (mem_idx),
        .wr_data (vb),
        .rd_data (dmem_rd_data),
        .busy    (dmem_busy)
    );

    // bypass from stage 2; load data comes straight from the memory port
    assign s2_fwd_val = s2_use_mem_reg ? dmem_rd_data : s2_val_reg;
    assign va = (s2_valid_reg && s2_wr_reg && (s2_rd_reg == s1_ra_reg)) ? s2_fwd_val : rf_a;
    assign vb = (s2_valid_reg && s2_wr_reg && (s2_rd_reg == s1_rb_reg)) ? s2_fwd_val : rf_b;

    // word index: small negative byte offsets still land on word zero
    assign diff         = va + s1_imm_reg - data_base_reg;
    assign pos_ok       = !diff[31] && (diff[31:2] < 30'(MEM_WORDS));
    assign neg_ok       = diff[31] && (&diff[31:2]) && (diff[1:0] != 2'b00);
    assign addr_ok      = pos_ok || neg_ok;
    assign mem_idx      = neg_ok ? '0 : diff[MEM_AW+1:2];
    assign mem_idx_wide = 32'(mem_idx);

    // operation decode and ALU
    always_comb begin
        alu_wr  = 1'b0;
        alu_val = '0;
        taken   = 1'b0;
        is_lw   = 1'b0;
        is_sw   = 1'b0;
        unique case (op_t'(s1_op_reg))
            OP_ADD: begin
                alu_wr  = 1'b1;
                alu_val = va + vb;
            end
            OP_ADDI: begin
                alu_wr  = 1'b1;
                alu_val = va + s1_imm_reg;
            end
            OP_SUB: begin
                alu_wr  = 1'b1;
                alu_val = va - vb;
            end
            OP_SUBI: begin
                alu_wr  = 1'b1;
                alu_val = va - s1_imm_reg;
            end
            OP_BEQ:  taken = (va == vb);
            OP_BNE:  taken = (va != vb);
            OP_BLE:  taken = ($signed(va) <= $signed(vb));
            OP_J:    taken = 1'b1;
            OP_LI: begin
                alu_wr  = 1'b1;
                alu_val = s1_imm_reg;
            end
            OP_LW:   is_lw = 1'b1;
            OP_SW:   is_sw = 1'b1;
            OP_NOP:  ;
            default: ;
        endcase
    end

    // write-back and memory decisions; register zero is never written
    assign rd_nonzero = (s1_rd_reg != '0);
    assign ex_wr      = (alu_wr || (is_lw && addr_ok)) && rd_nonzero;
    assign ex_use_mem = is_lw && addr_ok && rd_nonzero;
    assign ex_val     = (alu_wr && rd_nonzero) ? alu_val : '0;
    assign ex_mw      = is_sw && addr_ok;
    assign ex_err     = (is_lw || is_sw) && !addr_ok;
    assign ex_midx    = ((is_lw || is_sw) && addr_ok) ? mem_idx_wide[MIDX_W-1:0] : '0;

    assign dm_ctl.rd_en = s1_go && is_lw && addr_ok;
    assign dm_ctl.wr_en = s1_go && ex_mw;

    // next PC: fall through with wrap, or taken target folded into the depth
    assign pc_inc   = (pc_reg == PC_W'(PROG_DEPTH - 1)) ? '0 : pc_reg + PC_W'(1);
    assign tgt_mod  = target_mod(s1_tgt_reg, 32'(PROG_DEPTH));
    assign tgt_wide = 32'(tgt_mod);
    assign pc_next  = taken ? tgt_wide[PC_W-1:0] : pc_inc;
    assign npc_wide = 32'(pc_next);

    // register write leaves stage 2 with the result word
    assign rf_wr.en   = out_load && s2_wr_reg;
    assign rf_wr.idx  = s2_rd_reg;
    assign rf_wr.data = s2_fwd_val;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_base_reg <= DATA_BASE_RESET;
            pc_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                data_base_reg <= cfg_wr_data;
            end
            if (s1_go) begin
                pc_reg <= pc_next;
            end
            if (s1_adv) begin
                s1_valid_reg <= accept;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg  <= s_op;
            s1_rd_reg  <= s_dest_reg;
            s1_ra_reg  <= s_src_a;
            s1_rb_reg  <= s_src_b;
            s1_imm_reg <= s_immediate;
            s1_tgt_reg <= s_target;
        end
        if (s1_go) begin
            s2_npc_reg     <= npc_wide[PC_OUT_W-1:0];
            s2_taken_reg   <= taken;
            s2_wr_reg      <= ex_wr;
            s2_rd_reg      <= s1_rd_reg;
            s2_val_reg     <= ex_val;
            s2_use_mem_reg <= ex_use_mem;
            s2_mw_reg      <= ex_mw;
            s2_midx_reg    <= ex_midx;
            s2_err_reg     <= ex_err;
        end
        if (out_load) begin
            m_next_pc_reg         <= s2_npc_reg;
            m_branch_taken_reg    <= s2_taken_reg;
            m_reg_write_reg       <= s2_wr_reg;
            m_write_reg_index_reg <= s2_wr_reg ? s2_rd_reg : '0;
            m_write_value_reg     <= s2_fwd_val;
            m_mem_write_reg       <= s2_mw_reg;
            m_mem_index_reg       <= s2_midx_reg;
            m_addr_error_reg      <= s2_err_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_next_pc         = m_next_pc_reg;
    assign m_branch_taken    = m_branch_taken_reg;
    assign m_reg_write       = m_reg_write_reg;
    assign m_write_reg_index = m_write_reg_index_reg;
    assign m_write_value     = m_write_value_reg;
    assign m_mem_write       = m_mem_write_reg;
    assign m_mem_index       = m_mem_index_reg;
    assign m_addr_error      = m_addr_error_reg;

    // checks
    a_rf_no_zero_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr.en |-> (rf_wr.idx != '0))
        else $error("register zero written");

    a_dmem_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        dm_ctl.wr_en |-> !dm_ctl.rd_en)
        else $error("data memory read and write in one cycle");

    a_err_suppresses: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_addr_error_reg) |-> (!m_reg_write_reg && !m_mem_write_reg))
        else $error("address error with a write reported");

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted word lost before stage 1");

endmodule

>>> design/mseu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mseu_regfile.sv
// Register file: two RAM copies for two read ports, valid bits and last-write bypass.
`timescale 1ns / 1ps

module mseu_regfile
    import mseu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [REG_IDX_W-1:0] rd_addr_a,
    input  logic [REG_IDX_W-1:0] rd_addr_b,
    input  rf_wr_t               wr,
    output logic [WORD_W-1:0]    rd_data_a,
    output logic [WORD_W-1:0]    rd_data_b
);

    logic [NUM_REGS-1:0]  valid_reg;
    logic [REG_IDX_W-1:0] addr_a_reg;
    logic [REG_IDX_W-1:0] addr_b_reg;
    logic                 vld_a_reg;
    logic                 vld_b_reg;
    rf_wr_t               last_wr_reg;
    logic [WORD_W-1:0]    ram_a;
    logic [WORD_W-1:0]    ram_b;

    mseu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.idx),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (ram_a)
    );

    mseu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.idx),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (ram_b)
    );

    // valid bits, read address capture and most recent write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            vld_a_reg      <= 1'b0;
            vld_b_reg      <= 1'b0;
            last_wr_reg.en <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.idx] <= 1'b1;
                last_wr_reg       <= wr;
            end
            if (rd_en) begin
                vld_a_reg <= valid_reg[rd_addr_a];
                vld_b_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
    end

    // a write on the read edge is not yet in the RAM word: take it from the bypass
    always_comb begin
        if (last_wr_reg.en && (last_wr_reg.idx == addr_a_reg)) begin
            rd_data_a = last_wr_reg.data;
        end else begin
            rd_data_a = vld_a_reg ? ram_a : '0;
        end
        if (last_wr_reg.en && (last_wr_reg.idx == addr_b_reg)) begin
            rd_data_b = last_wr_reg.data;
        end else begin
            rd_data_b = vld_b_reg ? ram_b : '0;
        end
    end

endmodule

>>> design/mseu_dmem.sv
// Data memory: word RAM with a clearing sweep after reset.
`timescale 1ns / 1ps

module mseu_dmem
    import mseu_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT,
    localparam int ADDR_W = $clog2(MEM_WORDS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dmem_ctl_t         ctl,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WORD_W-1:0] wr_data,
    output logic [WORD_W-1:0] rd_data,
    output logic              busy
);

    logic              clear_active_reg;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;

    // one word zeroed per cycle after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end else if (clear_active_reg) begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(MEM_WORDS - 1)) begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // sweep owns the write port while it runs
    assign ram_wr_en   = clear_active_reg | ctl.wr_en;
    assign ram_wr_addr = clear_active_reg ? clear_addr_reg : addr;
    assign ram_wr_data = clear_active_reg ? '0 : wr_data;

    mseu_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    assign busy = clear_active_reg;

endmodule

>>> tb/mips_subset_execute_unit_top_tb.sv
// Self-checking testbench for the integer subset execute unit: directed table, random programs.
`timescale 1ns / 1ps

module mips_subset_execute_unit_top_tb;
    import mseu_pkg::*;

    localparam int MEM_DEPTH       = MEM_WORDS_DEFAULT;
    localparam int PC_DEPTH        = PROG_DEPTH_DEFAULT;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 5;   // pipeline is three deep
    localparam int DRAIN_CYCLES    = 10;
    localparam int PHASES          = 5;
    localparam int RANDOM_PHASE    = 2;   // this phase takes a random data base
    localparam int ITEMS_PER_PHASE = 380;
    localparam int CALM_ITEMS      = 150;
    localparam int HOLD_AT         = 500;
    localparam int HOLD_CYCLES     = 200;
    localparam int MAX_REPORTS     = 60;
    // longest correct quiet stretch is the clearing pass after reset
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DIR_ROWS        = 26;

    // op codes the block treats as nop
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd12;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

    localparam logic [WORD_W-1:0] EDGE_WORDS [4] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000
    };
    localparam logic [WORD_W-1:0] BASE_SETTINGS [PHASES] = '{
        32'h0000_0000, 32'hFFFF_FFFF, DATA_BASE_RESET, 32'h8000_0000, 32'hFFFF_F000
    };

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] ra;
        logic [REG_IDX_W-1:0] rb;
        logic [WORD_W-1:0]    imm;
        logic [TARGET_W-1:0]  tgt;
    } instr_t;

    typedef struct packed {
        logic [PC_OUT_W-1:0]  next_pc;
        logic                 taken;
        logic                 reg_wr;
        logic [REG_IDX_W-1:0] wr_idx;
        logic [WORD_W-1:0]    wr_val;
        logic                 mem_wr;
        logic [MIDX_W-1:0]    mem_idx;
        logic                 addr_err;
    } retire_t;

    typedef struct packed {
        instr_t  ins;
        logic    typed;   // expected word given in the row
        retire_t res;
    } stim_row_t;

    // DUT ports
    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [WORD_W-1:0]        cfg_wr_data = '0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op        = '0;
    logic [REG_IDX_W-1:0]     s_dest_reg  = '0;
    logic [REG_IDX_W-1:0]     s_src_a     = '0;
    logic [REG_IDX_W-1:0]     s_src_b     = '0;
    logic [WORD_W-1:0]        s_immediate = '0;
    logic [TARGET_W-1:0]      s_target    = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic [PC_OUT_W-1:0]      m_next_pc;
    logic                     m_branch_taken;
    logic                     m_reg_write;
    logic [REG_IDX_W-1:0]     m_write_reg_index;
    logic [WORD_W-1:0]        m_write_value;
    logic                     m_mem_write;
    logic [MIDX_W-1:0]        m_mem_index;
    logic                     m_addr_error;

    // architectural state as the core should see it
    logic [WORD_W-1:0]   gpr [NUM_REGS]   = '{default: '0};
    logic [WORD_W-1:0]   dmem [MEM_DEPTH] = '{default: '0};
    logic [PC_OUT_W-1:0] pc_model         = '0;
    logic [WORD_W-1:0]   model_base       = DATA_BASE_RESET;

    retire_t   retire_q [$];
    stim_row_t directed_rows [DIR_ROWS];

    int   err_count    = 0;
    int   results_seen = 0;
    int   idle_cycles  = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;
    logic recv_hold    = 1'b0;
    logic calm         = 1'b0;

    mips_subset_execute_unit_top #(
        .MEM_WORDS  (MEM_DEPTH),
        .PROG_DEPTH (PC_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_dest_reg        (s_dest_reg),
        .s_src_a           (s_src_a),
        .s_src_b           (s_src_b),
        .s_immediate       (s_immediate),
        .s_target          (s_target),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_next_pc         (m_next_pc),
        .m_branch_taken    (m_branch_taken),
        .m_reg_write       (m_reg_write),
        .m_write_reg_index (m_write_reg_index),
        .m_write_value     (m_write_value),
        .m_mem_write       (m_mem_write),
        .m_mem_index       (m_mem_index),
        .m_addr_error      (m_addr_error)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic instr_t mk_ins(input logic [OP_W-1:0] op, input int rd, input int ra,
                                      input int rb, input logic [WORD_W-1:0] imm,
                                      input int tgt);
        instr_t ins;
        ins.op  = op;
        ins.rd  = REG_IDX_W'(rd);
        ins.ra  = REG_IDX_W'(ra);
        ins.rb  = REG_IDX_W'(rb);
        ins.imm = imm;
        ins.tgt = TARGET_W'(tgt);
        return ins;
    endfunction

    function automatic retire_t mk_res(input int pc, input bit taken, input bit rw,
                                       input int widx, input logic [WORD_W-1:0] wval,
                                       input bit mw, input int midx, input bit err);
        retire_t r;
        r.next_pc  = PC_OUT_W'(pc);
        r.taken    = taken;
        r.reg_wr   = rw;
        r.wr_idx   = REG_IDX_W'(widx);
        r.wr_val   = wval;
        r.mem_wr   = mw;
        r.mem_idx  = MIDX_W'(midx);
        r.addr_err = err;
        return r;
    endfunction

    // base + offset - data base, quotient truncated toward zero; 0 when out of range
    function automatic logic map_word(input logic [WORD_W-1:0] base_val,
                                      input logic [WORD_W-1:0] offset,
                                      output logic [MIDX_W-1:0] idx);
        logic [WORD_W-1:0] diff;
        diff = base_val + offset - model_base;
        idx  = '0;
        if (diff[WORD_W-1]) begin
            return ((-diff) >> 2) == 0;
        end
        if ((diff >> 2) >= MEM_DEPTH) begin
            return 1'b0;
        end
        idx = MIDX_W'(diff >> 2);
        return 1'b1;
    endfunction

    // retire one instruction against the state above and give the word it must produce
    function automatic retire_t retire_instr(input instr_t ins);
        retire_t           r;
        logic [WORD_W-1:0] va;
        logic [WORD_W-1:0] vb;
        logic [WORD_W-1:0] wval;
        logic [MIDX_W-1:0] idx;
        logic              wr;
        r    = '0;
        va   = gpr[ins.ra];
        vb   = gpr[ins.rb];
        wr   = 1'b0;
        wval = '0;
        r.next_pc = PC_OUT_W'((pc_model + 1) % PC_DEPTH);
        case (ins.op)
            OP_ADD:  begin wr = 1'b1; wval = va + vb; end
            OP_ADDI: begin wr = 1'b1; wval = va + ins.imm; end
            OP_SUB:  begin wr = 1'b1; wval = va - vb; end
            OP_SUBI: begin wr = 1'b1; wval = va - ins.imm; end
            OP_BEQ:  r.taken = (va == vb);
            OP_BNE:  r.taken = (va != vb);
            OP_BLE:  r.taken = ($signed(va) <= $signed(vb));
            OP_J:    r.taken = 1'b1;
            OP_LI:   begin wr = 1'b1; wval = ins.imm; end
            OP_LW: begin
                if (map_word(va, ins.imm, idx)) begin
                    wr        = 1'b1;
                    wval      = dmem[idx];
                    r.mem_idx = idx;
                end else begin
                    r.addr_err = 1'b1;
                end
            end
            OP_SW: begin
                if (map_word(va, ins.imm, idx)) begin
                    dmem[idx] = vb;
                    r.mem_wr  = 1'b1;
                    r.mem_idx = idx;
                end else begin
                    r.addr_err = 1'b1;
                end
            end
            default: ;
        endcase
        if (r.taken) begin
            r.next_pc = PC_OUT_W'(ins.tgt % PC_DEPTH);
        end
        // register zero swallows writes
        if (wr && ins.rd != 0) begin
            gpr[ins.rd] = wval;
            r.reg_wr    = 1'b1;
            r.wr_idx    = ins.rd;
            r.wr_val    = wval;
        end
        pc_model = r.next_pc;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_operand();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
            return 32'($urandom_range(0, 16)) - 32'd8;
        end
        if (pick < 4) begin
            return EDGE_WORDS[$urandom_range(0, 3)];
        end
        return $urandom;
    endfunction

    // byte offset so that the access lands where wanted, given the base register now
    function automatic logic [WORD_W-1:0] mem_offset(input logic [REG_IDX_W-1:0] base_reg);
        int unsigned       pick;
        logic [WORD_W-1:0] byte_off;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            byte_off = 32'($urandom_range(0, 63));
        end else if (pick < 14) begin
            byte_off = 32'($urandom_range(0, MEM_DEPTH * 4 - 1));
        end else if (pick < 17) begin
            // edges: just below word zero (truncates to it), one word below, the top
            case ($urandom_range(0, 3))
                0:       byte_off = 32'd0 - 32'($urandom_range(1, 3));
                1:       byte_off = 32'd0 - 32'd4;
                2:       byte_off = 32'(MEM_DEPTH * 4);
                default: byte_off = 32'(MEM_DEPTH * 4 - 1);
            endcase
        end else begin
            return rand_operand();
        end
        return model_base + byte_off - gpr[base_reg];
    endfunction

    function automatic instr_t make_instr();
        instr_t ins;
        int     roll;
        ins.op  = OP_NOP;
        ins.rd  = REG_IDX_W'($urandom_range(0, 31));
        ins.ra  = REG_IDX_W'($urandom_range(0, 31));
        ins.rb  = REG_IDX_W'($urandom_range(0, 31));
        ins.imm = rand_operand();
        ins.tgt = TARGET_W'($urandom);
        roll    = $urandom_range(0, 99);
        if (roll < 12) begin
            ins.op = roll[0] ? OP_SUB : OP_ADD;
        end else if (roll < 22) begin
            ins.op = roll[0] ? OP_SUBI : OP_ADDI;
        end else if (roll < 30) begin
            ins.op = OP_LI;
        end else if (roll < 80) begin
            ins.op  = (roll < 55) ? OP_LW : OP_SW;
            ins.imm = mem_offset(ins.ra);
        end else if (roll < 92) begin
            case (roll % 3)
                0:       ins.op = OP_BEQ;
                1:       ins.op = OP_BNE;
                default: ins.op = OP_BLE;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                ins.rb = ins.ra;
            end
        end else if (roll < 96) begin
            ins.op = OP_J;
        end else if (roll < 98) begin
            ins.op = OP_NOP;
        end else begin
            ins.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return ins;
    endfunction

    // offer one word, wait for the handshake, then record what it must retire as
    task automatic send_instr(input instr_t ins, input logic typed, input retire_t given);
        retire_t r;
        int      gap;
        gap = 0;
        if (!calm && !recv_hold && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= ins.op;
        s_dest_reg  <= ins.rd;
        s_src_a     <= ins.ra;
        s_src_b     <= ins.rb;
        s_immediate <= ins.imm;
        s_target    <= ins.tgt;
        do @(posedge aclk); while (!s_ready);
        r = retire_instr(ins);
        retire_q.insert(retire_q.size(), typed ? given : r);
    endtask

    // data base changes only with the pipeline empty
    task automatic write_data_base(input logic [WORD_W-1:0] value);
        while (retire_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_base = value;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        end
    endtask

    // result side: check each word, random stalls, one long hold-off
    always @(posedge aclk) begin
        retire_t got;
        retire_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_next_pc, m_branch_taken, m_reg_write, m_write_reg_index,
                        m_write_value, m_mem_write, m_mem_index, m_addr_error};
                if (retire_q.size() == 0) begin
                    err_count++;
                    $display("%0t: result word with nothing expected, next_pc 0x%0h",
                             $time, got.next_pc);
                end else begin
                    want = retire_q.pop_front();
                    check_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
                    check_field("branch_taken", 32'(want.taken), 32'(got.taken));
                    check_field("reg_write", 32'(want.reg_wr), 32'(got.reg_wr));
                    check_field("write_reg_index", 32'(want.wr_idx), 32'(got.wr_idx));
                    check_field("write_value", want.wr_val, got.wr_val);
                    check_field("mem_write", 32'(want.mem_wr), 32'(got.mem_wr));
                    check_field("mem_index", 32'(want.mem_idx), 32'(got.mem_idx));
                    check_field("addr_error", 32'(want.addr_err), 32'(got.addr_err));
                end
                results_seen++;
            end
            if (results_seen == HOLD_AT && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            recv_hold <= (hold_left != 0);
        end
    end

    // watchdog: too long without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // instruction side
    initial begin
        logic [WORD_W-1:0] base_val;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // written during the clearing pass; directed rows assume this base
        write_data_base(DATA_BASE_RESET);

        directed_rows = '{
            '{mk_ins(OP_NOP, 0, 0, 0, 32'h0, 0), 1'b1, mk_res(1, 0, 0, 0, 32'h0, 0, 0, 0)},
            '{mk_ins(OP_LI, 1, 0, 0, 32'h7FFF_FFFF, 0), 1'b1,
              mk_res(2, 0, 1, 1, 32'h7FFF_FFFF, 0, 0, 0)},
            '{mk_ins(OP_LI, 2, 0, 0, 32'h8000_0000, 0), 1'b1,
              mk_res(3, 0, 1, 2, 32'h8000_0000, 0, 0, 0)},
            // add wraps past the largest positive value
            '{mk_ins(OP_ADDI, 3, 1, 0, 32'h1, 0), 1'b1,
              mk_res(4, 0, 1, 3, 32'h8000_0000, 0, 0, 0)},
            '{mk_ins(OP_SUB, 4, 2, 1, 32'h0, 0), 1'b0, '0},
            '{mk_ins(OP_SUBI, 5, 2, 0, 32'h1, 0), 1'b0, '0},
            // register zero keeps zero
            '{mk_ins(OP_ADD, 0, 1, 1, 32'h0, 0), 1'b1, mk_res(7, 0, 0, 0, 32'h0, 0, 0, 0)},
            '{mk_ins(OP_LI, 6, 0, 0, DATA_BASE_RESET, 0), 1'b0, '0},
            '{mk_ins(OP_SW, 0, 6, 1, 32'h0, 0), 1'b1, mk_res(9, 0, 0, 0, 32'h0, 1, 0, 0)},
            '{mk_ins(OP_SW, 0, 6, 2, 32'd4092, 0), 1'b1,
              mk_res(10, 0, 0, 0, 32'h0, 1, 1023, 0)},
            // one word past the top
            '{mk_ins(OP_SW, 0, 6, 1, 32'd4096, 0), 1'b1, mk_res(11, 0, 0, 0, 32'h0, 0, 0, 1)},
            // just below word zero truncates onto it
            '{mk_ins(OP_LW, 7, 6, 0, 32'hFFFF_FFFF, 0), 1'b0, '0},
            '{mk_ins(OP_LW, 8, 6, 0, 32'hFFFF_FFFC, 0), 1'b1,
              mk_res(13, 0, 0, 0, 32'h0, 0, 0, 1)},
            // load into its own base register
            '{mk_ins(OP_LW, 6, 6, 0, 32'd4092, 0), 1'b0, '0},
            '{mk_ins(OP_BEQ, 0, 1, 1, 32'h0, 1023), 1'b1,
              mk_res(1023, 1, 0, 0, 32'h0, 0, 0, 0)},
            // not taken from the last slot wraps to zero
            '{mk_ins(OP_BNE, 0, 1, 1, 32'h0, 5), 1'b1, mk_res(0, 0, 0, 0, 32'h0, 0, 0, 0)},
            '{mk_ins(OP_BLE, 0, 2, 1, 32'h0, 100), 1'b0, '0},
            '{mk_ins(OP_BLE, 0, 1, 2, 32'h0, 200), 1'b0, '0},
            '{mk_ins(OP_BLE, 0, 4, 4, 32'h0, 300), 1'b0, '0},
            '{mk_ins(OP_BNE, 0, 1, 2, 32'h0, 0), 1'b0, '0},
            '{mk_ins(OP_J, 0, 0, 0, 32'h0, 512), 1'b1, mk_res(512, 1, 0, 0, 32'h0, 0, 0, 0)},
            '{mk_ins(OP_SPARE_FIRST, 9, 1, 2, 32'h5, 7), 1'b0, '0},
            '{mk_ins(OP_SPARE_LAST, 31, 31, 31, 32'hFFFF_FFFF, 1023), 1'b0, '0},
            '{mk_ins(OP_LW, 9, 0, 0, 32'h7FFF_FFFF, 0), 1'b0, '0},
            '{mk_ins(OP_SW, 0, 0, 3, 32'h8000_0000, 0), 1'b0, '0},
            '{mk_ins(OP_LI, 31, 0, 0, 32'h0, 0), 1'b0, '0}
        };
        foreach (directed_rows[i]) begin
            send_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].res);
        end
        s_valid <= 1'b0;

        // random programs, one data base per phase
        for (int p = 0; p < PHASES; p++) begin
            base_val = (p == RANDOM_PHASE) ? 32'($urandom) : BASE_SETTINGS[p];
            write_data_base(base_val);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == PHASES - 1 && n == ITEMS_PER_PHASE - CALM_ITEMS) begin
                    calm <= 1'b1;
                end
                send_instr(make_instr(), 1'b0, '0);
            end
            s_valid <= 1'b0;
        end

        // drain, then give stray words a chance to show up
        while (retire_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
